// ===== hw/rtl/aes128_ctr_drbg_macros.svh =====
// Assertion macros for the DRBG block
`ifndef AES128_CTR_DRBG_MACROS_SVH
`define AES128_CTR_DRBG_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== hw/rtl/acd_pkg.sv =====
`default_nettype none
package acd_pkg;
  localparam int MaxRequestBitsDefault = 4096;
  localparam logic [48:0] CounterLimit = 49'h1_0000_0000_0000;
  localparam logic [127:0] KeyMask = 128'h5A45E7A4571D7F3661307EFACEFCE258;
  localparam logic [127:0] VMask   = 128'h78FEB271B9C228F392A3B660CEDA8803;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusExh  = 2'd1;
  localparam logic [1:0] StatusLen  = 2'd2;

  localparam logic ActInst = 1'b0;

  typedef struct packed {
    logic         start;
    logic [127:0] key;
    logic [127:0] blk;
  } acd_aes_req_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/acd_aes_core.sv =====
`default_nettype none
`include "aes128_ctr_drbg_macros.svh"
// Iterative AES-128: one round and one key expansion step per cycle
module acd_aes_core import acd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire acd_aes_req_t req,
  output logic              done,
  output logic [127:0]      result
);
  logic [127:0] st, rk;
  logic [3:0]   rnd;
  logic         busy;
  logic [7:0]   rc;
  logic [127:0] rk_next, st_next;
  logic [7:0]   sb [16];
  logic [7:0]   mc [16];

  // expand next round key, byte 0 in low bits
  always_comb begin
    logic [31:0] w0, w1, w2, w3, g;
    w0 = rk[31:0]; w1 = rk[63:32]; w2 = rk[95:64]; w3 = rk[127:96];
    g = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]), sbox(w3[15:8]) ^ rc};
    w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    rk_next = {w3, w2, w1, w0};
  end

  // sub bytes, shift rows, mix columns (skipped in round 10), add next round key
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        sb[4*c+i] = sbox(st[8*(4*((c+i)%4)+i) +: 8]);
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[4*c]   = (rnd == 4'd10) ? a0 : a0 ^ al ^ xtime(a0 ^ a1);
      mc[4*c+1] = (rnd == 4'd10) ? a1 : a1 ^ al ^ xtime(a1 ^ a2);
      mc[4*c+2] = (rnd == 4'd10) ? a2 : a2 ^ al ^ xtime(a2 ^ a3);
      mc[4*c+3] = (rnd == 4'd10) ? a3 : a3 ^ al ^ xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) st_next[8*i +: 8] = mc[i] ^ rk_next[8*i +: 8];
  end

  // run rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 4'd0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      rnd  <= 4'd1;
      rc   <= 8'h01;
      rk   <= req.key;
      st   <= req.blk ^ req.key;
      done <= 1'b0;
    end else if (busy) begin
      st   <= st_next;
      rk   <= rk_next;
      rc   <= xtime(rc);
      rnd  <= rnd + 4'd1;
      done <= (rnd == 4'd10);
      if (rnd == 4'd10) busy <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end
  assign result = st;

  `ASSERT_NEXT(a_done_end, clk, rst, busy && rnd == 4'd10 && !req.start, done && !busy)
  `ASSERT_IMPL(a_rnd_rng, clk, rst, busy, rnd >= 4'd1 && rnd <= 4'd10)
  `ASSERT_IMPL(a_no_restart, clk, rst, busy, !req.start)
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_ctr_drbg.sv =====
`default_nettype none
// channel | dir | handshake        | payload
// in      | in  | in_valid/stall   | action, request_bits
// out     | out | out_valid/stall  | random_word, valid_bytes, status, last
// cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
// Each 128-bit block is encrypted on the one AES core and gives two output
// words; a generate runs its blocks and then the two update encryptions,
// which use the same core.
// rst is synchronous; it returns state to S_IDLE and clears key, V and count to zero.
// A stalled output holds the block; no new input while a request runs.
module aes128_ctr_drbg import acd_pkg::*; #(
  parameter int MAX_REQUEST_BITS = MaxRequestBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [12:0] request_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      random_word,
  output logic [3:0]       valid_bytes,
  output logic [1:0]       status,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_ENC = 6'b000010, S_OUT = 6'b000100,
    S_UPK = 6'b001000, S_UPV = 6'b010000, S_WAIT = 6'b100000
  } state_t;

  state_t       state;
  logic [63:0]  seed [4];
  logic [127:0] key, v, vnext, newkey, blk;
  logic [48:0]  count;
  logic [12:0]  bits;
  logic [9:0]   bytes_left;
  logic         half;
  acd_aes_req_t req;
  logic         done;
  logic [127:0] res;
  logic         in_acc, out_acc;
  logic [63:0]  w;
  logic [3:0]   nb;
  logic [2:0]   lb;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) for (int i = 0; i < 4; i++) seed[i] <= '0;
    else if (cfg_valid) seed[cfg_index] <= cfg_data;
  end

  // mask current word: zero unused bytes, right-align partial byte
  always_comb begin
    logic [63:0] raw;
    raw = half ? blk[127:64] : blk[63:0];
    nb = (bytes_left > 10'd8) ? 4'd8 : bytes_left[3:0];
    lb = bits[2:0];
    w = '0;
    for (int i = 0; i < 8; i++)
      if (4'(i) < nb) w[8*i +: 8] = raw[8*i +: 8];
    if (lb != 3'd0 && bytes_left <= 10'd8)
      w[8*(nb-4'd1) +: 8] = raw[8*(nb-4'd1) +: 8] >> (4'd8 - {1'b0, lb});
  end

  // start the first block, the next block, or the two update encryptions
  always_comb begin
    req.start = 1'b0;
    req.key   = key;
    req.blk   = v + 128'd1;
    if (state == S_WAIT) begin
      req.start = 1'b1;
    end else if (state == S_OUT && out_acc && bytes_left <= 10'd8) begin
      req.start = 1'b1;
    end else if (state == S_OUT && out_acc && half) begin
      req.start = 1'b1;
    end else if (state == S_UPK && done) begin
      req.start = 1'b1;
      req.blk   = v + 128'd2;
    end
  end

  acd_aes_core u_aes (.clk(clk), .rst(rst), .req(req), .done(done), .result(res));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      key <= '0; v <= '0; count <= '0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_acc) begin
          bits <= request_bits;
          if (action == ActInst) begin
            key   <= {seed[1], seed[0]} ^ KeyMask;
            v     <= {seed[3], seed[2]} ^ VMask;
            count <= 49'd1;
          end else if (count > CounterLimit || request_bits == 13'd0 ||
                       request_bits > 13'(MAX_REQUEST_BITS)) begin
            out_valid   <= 1'b1;
            random_word <= '0; valid_bytes <= '0; last <= 1'b1;
            status <= (count > CounterLimit) ? StatusExh : StatusLen;
          end else begin
            state <= S_WAIT;
            bytes_left <= 10'((request_bits + 13'd7) >> 3);
          end
        end
        S_WAIT: begin
          state <= S_ENC; vnext <= v + 128'd1;
        end
        S_ENC: if (done) begin
          blk <= res; half <= 1'b0; v <= vnext; state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_acc) begin
            if (!out_valid && !out_acc) begin
              out_valid <= 1'b1; random_word <= w; valid_bytes <= nb;
              status <= StatusOk; last <= (bytes_left <= 10'd8);
            end else begin
              if (bytes_left <= 10'd8) state <= S_UPK;
              else begin
                bytes_left <= bytes_left - 10'd8;
                if (half) begin state <= S_ENC; vnext <= v + 128'd1; end
                half <= ~half;
              end
            end
          end
        end
        S_UPK: if (done) begin newkey <= res; state <= S_UPV; end
        S_UPV: if (done) begin
          key <= newkey; v <= res; count <= count + 49'd1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_ok_nb, clk, rst, out_valid && status == StatusOk, valid_bytes != 4'd0)
  `ASSERT_IMPL(a_err_last, clk, rst, out_valid && status != StatusOk, last && random_word == '0)
  `ASSERT_IMPL(a_idle_acc, clk, rst, in_acc, state == S_IDLE)
endmodule
`default_nettype wire
